/* src/yaml_lc_pkg.sv */
// Shared constants, enums and the line record type of the YAML line classifier.
`timescale 1ns / 1ps

package yaml_lc_pkg;

  localparam int unsigned OffsetWidthDflt = 32;
  localparam int unsigned IndentWidthDflt = 16;

  localparam int unsigned OutOffsetWidth = 32;
  localparam int unsigned OutIndentWidth = 16;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;

  // marker progress: 1..3 marker bytes seen, 4 = marker then whitespace
  localparam logic [2:0] MarkLen  = 3'd3;
  localparam logic [2:0] MarkDone = 3'd4;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_TABWS,
    PH_CONTENT
  } phase_e;

  typedef enum logic [1:0] {
    MK_NONE,
    MK_DASH,
    MK_DOT
  } mark_e;

  typedef struct packed {
    logic [OutOffsetWidth-1:0] line_begin;
    logic [OutOffsetWidth-1:0] line_finish;
    logic [OutIndentWidth-1:0] indent;
    logic [7:0]                first_byte;
    logic                      blank;
    logic                      has_tab;
    logic                      comment;
    logic                      directive;
    logic                      doc_start;
    logic                      doc_end;
    logic                      final_res;
  } rec_t;

endpackage

/* src/yaml_lc_scan.sv */
// Running line state and per-word record classification.
`timescale 1ns / 1ps

module yaml_lc_scan #(
  parameter int unsigned OFFSET_WIDTH = yaml_lc_pkg::OffsetWidthDflt,
  parameter int unsigned INDENT_WIDTH = yaml_lc_pkg::IndentWidthDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        text_byte_i,
  input  logic              no_byte_i,
  input  logic              end_of_text_i,
  output logic              emit_o,
  output yaml_lc_pkg::rec_t rec_o
);

  logic [OFFSET_WIDTH-1:0] byte_off_q, byte_off_d;
  logic [OFFSET_WIDTH-1:0] line_beg_q, line_beg_d;
  logic [INDENT_WIDTH-1:0] spc_q, spc_c, spc_d;
  yaml_lc_pkg::phase_e     phase_q, phase_c, phase_d;
  logic [7:0]              lead_q, lead_c, lead_d;
  logic                    tab_q, tab_c, tab_d;
  logic [2:0]              prog_q, prog_c, prog_d;
  yaml_lc_pkg::mark_e      kind_q, kind_c, kind_d;
  logic                    pend_cr_q, pend_cr_d;

  logic                    is_brk, is_ws, crlf_tail, content;
  logic                    brk_emit, eot_emit, clear;
  logic [OFFSET_WIDTH-1:0] off_inc, finish;
  logic [7:0]              want;
  logic                    col0;

  logic [yaml_lc_pkg::OutOffsetWidth-1:0] out_beg, out_fin;
  logic [yaml_lc_pkg::OutIndentWidth-1:0] out_ind;

  assign is_brk    = (text_byte_i == yaml_lc_pkg::ChLf) || (text_byte_i == yaml_lc_pkg::ChCr);
  assign is_ws     = (text_byte_i == yaml_lc_pkg::ChSpace) || (text_byte_i == yaml_lc_pkg::ChTab);
  assign crlf_tail = pend_cr_q && (text_byte_i == yaml_lc_pkg::ChLf);
  assign content   = !no_byte_i && !crlf_tail && !is_brk;
  assign off_inc   = byte_off_q + OFFSET_WIDTH'(1);
  assign want      = (kind_q == yaml_lc_pkg::MK_DASH) ? yaml_lc_pkg::ChDash : yaml_lc_pkg::ChDot;

  // line state after this word's content byte; equals the held state otherwise
  always_comb begin
    spc_c   = spc_q;
    phase_c = phase_q;
    lead_c  = lead_q;
    tab_c   = tab_q;
    prog_c  = prog_q;
    kind_c  = kind_q;
    if (content) begin
      unique case (phase_q)
        yaml_lc_pkg::PH_LEAD: begin
          if (text_byte_i == yaml_lc_pkg::ChSpace) begin
            if (!(&spc_q)) spc_c = spc_q + INDENT_WIDTH'(1);
          end else if (text_byte_i == yaml_lc_pkg::ChTab) begin
            tab_c   = 1'b1;
            lead_c  = yaml_lc_pkg::ChTab;
            phase_c = yaml_lc_pkg::PH_TABWS;
          end else begin
            lead_c  = text_byte_i;
            phase_c = yaml_lc_pkg::PH_CONTENT;
            if ((spc_q == '0) && (text_byte_i == yaml_lc_pkg::ChDash ||
                                  text_byte_i == yaml_lc_pkg::ChDot)) begin
              kind_c = (text_byte_i == yaml_lc_pkg::ChDash) ? yaml_lc_pkg::MK_DASH
                                                            : yaml_lc_pkg::MK_DOT;
              prog_c = 3'd1;
            end
          end
        end
        yaml_lc_pkg::PH_TABWS: begin
          if (!is_ws) phase_c = yaml_lc_pkg::PH_CONTENT;
        end
        yaml_lc_pkg::PH_CONTENT: begin
          if (kind_q != yaml_lc_pkg::MK_NONE) begin
            if (prog_q < yaml_lc_pkg::MarkLen) begin
              if (text_byte_i == want) prog_c = prog_q + 3'd1;
              else kind_c = yaml_lc_pkg::MK_NONE;
            end else if (prog_q == yaml_lc_pkg::MarkLen) begin
              if (is_ws) prog_c = yaml_lc_pkg::MarkDone;
              else kind_c = yaml_lc_pkg::MK_NONE;
            end
          end
        end
        default: phase_c = phase_q;
      endcase
    end
  end

  assign brk_emit = !no_byte_i && !crlf_tail && is_brk;

  always_comb begin
    byte_off_d = no_byte_i ? byte_off_q : off_inc;
    line_beg_d = line_beg_q;
    pend_cr_d  = pend_cr_q;
    if (!no_byte_i) begin
      pend_cr_d = brk_emit && (text_byte_i == yaml_lc_pkg::ChCr);
      if (crlf_tail || brk_emit) line_beg_d = off_inc;
    end
  end

  // partial last line flushed on the end mark
  assign eot_emit = end_of_text_i && !brk_emit && (line_beg_d != byte_off_d);
  assign finish   = brk_emit ? byte_off_q : byte_off_d;
  assign clear    = brk_emit || end_of_text_i;

  always_comb begin
    if (clear) begin
      spc_d   = '0;
      phase_d = yaml_lc_pkg::PH_LEAD;
      lead_d  = '0;
      tab_d   = 1'b0;
      prog_d  = '0;
      kind_d  = yaml_lc_pkg::MK_NONE;
    end else begin
      spc_d   = spc_c;
      phase_d = phase_c;
      lead_d  = lead_c;
      tab_d   = tab_c;
      prog_d  = prog_c;
      kind_d  = kind_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_off_q <= '0;
      line_beg_q <= '0;
      spc_q      <= '0;
      phase_q    <= yaml_lc_pkg::PH_LEAD;
      lead_q     <= '0;
      tab_q      <= 1'b0;
      prog_q     <= '0;
      kind_q     <= yaml_lc_pkg::MK_NONE;
      pend_cr_q  <= 1'b0;
    end else if (take_i) begin
      byte_off_q <= end_of_text_i ? '0 : byte_off_d;
      line_beg_q <= end_of_text_i ? '0 : line_beg_d;
      spc_q      <= spc_d;
      phase_q    <= phase_d;
      lead_q     <= lead_d;
      tab_q      <= tab_d;
      prog_q     <= prog_d;
      kind_q     <= kind_d;
      pend_cr_q  <= end_of_text_i ? 1'b0 : pend_cr_d;
    end
  end

  assign emit_o = brk_emit || eot_emit;
  assign col0   = (spc_c == '0);

  // record fields; offsets and indent fit to the fixed output widths
  generate
    if (OFFSET_WIDTH >= yaml_lc_pkg::OutOffsetWidth) begin : g_off_trunc
      assign out_beg = line_beg_q[yaml_lc_pkg::OutOffsetWidth-1:0];
      assign out_fin = finish[yaml_lc_pkg::OutOffsetWidth-1:0];
    end else begin : g_off_ext
      assign out_beg = {{(yaml_lc_pkg::OutOffsetWidth-OFFSET_WIDTH){1'b0}}, line_beg_q};
      assign out_fin = {{(yaml_lc_pkg::OutOffsetWidth-OFFSET_WIDTH){1'b0}}, finish};
    end
    if (INDENT_WIDTH >= yaml_lc_pkg::OutIndentWidth) begin : g_ind_trunc
      assign out_ind = spc_c[yaml_lc_pkg::OutIndentWidth-1:0];
    end else begin : g_ind_ext
      assign out_ind = {{(yaml_lc_pkg::OutIndentWidth-INDENT_WIDTH){1'b0}}, spc_c};
    end
  endgenerate

  always_comb begin
    rec_o.line_begin  = out_beg;
    rec_o.line_finish = out_fin;
    rec_o.indent      = out_ind;
    rec_o.final_res   = end_of_text_i;
    rec_o.first_byte  = '0;
    rec_o.blank       = 1'b0;
    rec_o.has_tab     = 1'b0;
    rec_o.comment     = 1'b0;
    rec_o.directive   = 1'b0;
    rec_o.doc_start   = 1'b0;
    rec_o.doc_end     = 1'b0;
    unique case (phase_c)
      yaml_lc_pkg::PH_LEAD: begin
        rec_o.blank = 1'b1;
      end
      yaml_lc_pkg::PH_TABWS: begin
        rec_o.blank   = 1'b1;
        rec_o.has_tab = col0;
      end
      yaml_lc_pkg::PH_CONTENT: begin
        if (tab_c) begin
          rec_o.has_tab    = 1'b1;
          rec_o.first_byte = yaml_lc_pkg::ChTab;
        end else begin
          rec_o.first_byte = lead_c;
          priority if (lead_c == yaml_lc_pkg::ChHash) begin
            rec_o.comment = 1'b1;
          end else if (lead_c == yaml_lc_pkg::ChPct && col0) begin
            rec_o.directive = 1'b1;
          end else if (kind_c != yaml_lc_pkg::MK_NONE && prog_c >= yaml_lc_pkg::MarkLen) begin
            rec_o.doc_start = (kind_c == yaml_lc_pkg::MK_DASH);
            rec_o.doc_end   = (kind_c == yaml_lc_pkg::MK_DOT);
          end else begin
            rec_o.comment = 1'b0;
          end
        end
      end
      default: rec_o.blank = 1'b0;
    endcase
  end

endmodule

/* src/yaml_lc_out.sv */
// Output register for line records, with stall handling toward the input side.
`timescale 1ns / 1ps

module yaml_lc_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              take_o,
  input  logic              emit_i,
  input  yaml_lc_pkg::rec_t rec_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output yaml_lc_pkg::rec_t rec_o
);

  logic              valid_q;
  yaml_lc_pkg::rec_t rec_q;
  logic              advance;

  // register can be refilled when empty or when its word leaves this cycle
  assign advance    = !valid_q || !out_stall_i;
  assign in_stall_o = !advance;
  assign take_o     = in_valid_i && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= take_o && emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && take_o && emit_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

/* src/yaml_line_classifier.sv */
// Top level of the byte-serial YAML line classifier.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+------------------------------------------
//   in      | in  | in_valid_i / in_stall_o | text_byte_i, no_byte_i, end_of_text_i
//   out     | out | out_valid_o / out_stall_i | line_begin_o .. final_res_o (one record)
//
// One byte is taken per cycle unless output stalls; the line state updates in the same
// cycle and a record, when the byte ends a line, reaches the output register next cycle.
// Reset clears the offsets and line state; the output register starts empty.
// A stalled output word holds; input is taken whenever the output register is empty
// or its word leaves in the same cycle.
`timescale 1ns / 1ps

module yaml_line_classifier #(
  parameter int unsigned OFFSET_WIDTH = yaml_lc_pkg::OffsetWidthDflt,
  parameter int unsigned INDENT_WIDTH = yaml_lc_pkg::IndentWidthDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        no_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] line_begin_o,
  output logic [31:0] line_finish_o,
  output logic [15:0] indent_o,
  output logic [7:0]  first_byte_o,
  output logic        blank_o,
  output logic        has_tab_o,
  output logic        comment_o,
  output logic        directive_o,
  output logic        doc_start_o,
  output logic        doc_end_o,
  output logic        final_res_o
);

  logic              take;
  logic              emit;
  yaml_lc_pkg::rec_t rec;
  yaml_lc_pkg::rec_t rec_out;

  yaml_lc_scan #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .INDENT_WIDTH(INDENT_WIDTH)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .text_byte_i  (text_byte_i),
    .no_byte_i    (no_byte_i),
    .end_of_text_i(end_of_text_i),
    .emit_o       (emit),
    .rec_o        (rec)
  );

  yaml_lc_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .take_o     (take),
    .emit_i     (emit),
    .rec_i      (rec),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .rec_o      (rec_out)
  );

  assign line_begin_o  = rec_out.line_begin;
  assign line_finish_o = rec_out.line_finish;
  assign indent_o      = rec_out.indent;
  assign first_byte_o  = rec_out.first_byte;
  assign blank_o       = rec_out.blank;
  assign has_tab_o     = rec_out.has_tab;
  assign comment_o     = rec_out.comment;
  assign directive_o   = rec_out.directive;
  assign doc_start_o   = rec_out.doc_start;
  assign doc_end_o     = rec_out.doc_end;
  assign final_res_o   = rec_out.final_res;

endmodule
